>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every rising edge while reset is released.
`define LUTM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define LUTM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/core/lutm_pkg.sv
// Shared constants and types of the 3D color cube mapper.
// Used by lutm_remap, lutm_lerp and the top level; depends on nothing.
`default_nettype none
package lutm_pkg;
  localparam int MAX_CUBE_SIZE = 33;
  localparam int SAMPLE_BITS   = 20;
  localparam int FRAC_BITS     = 16;
  localparam int TABLE_DEPTH   = MAX_CUBE_SIZE * MAX_CUBE_SIZE * MAX_CUBE_SIZE;
  localparam int ADDR_W        = 16;
  localparam int SIZE_W        = 6;
  localparam int SQ_W          = 11;
  localparam int SCALE_W       = 24;
  localparam int ENTRY_W       = 3 * SAMPLE_BITS;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam logic [CFG_IDX_W-1:0] REG_CUBE_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DMIN_RED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DMIN_GREEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DMIN_BLUE   = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                pixel;
    logic                last;
    logic [ADDR_W-1:0]   idx;
    logic [ENTRY_W-1:0]  entry;
  } side_t;
endpackage
`default_nettype wire

>>> rtl/core/lutm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; holds one copy of the color table.
`default_nettype none
module lutm_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 35937
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/lutm_remap.sv
// Three-stage remap of one channel to a clamped cube coordinate.
// Uses lutm_pkg for widths.
`default_nettype none
module lutm_remap (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire lutm_pkg::sample_t                   x,
  input  wire lutm_pkg::sample_t                   dmin,
  input  wire logic [lutm_pkg::SCALE_W-1:0]        scale,
  input  wire logic [lutm_pkg::SIZE_W-1:0]         size,
  output logic      [lutm_pkg::SIZE_W-1:0]         crd,
  output logic      [lutm_pkg::FRAC_BITS-1:0]      frac
);
  localparam int DW = lutm_pkg::SAMPLE_BITS + 1;
  localparam int PW = DW + lutm_pkg::SCALE_W + 1;
  localparam int CW = lutm_pkg::SIZE_W + lutm_pkg::FRAC_BITS;
  localparam int HW = PW - lutm_pkg::FRAC_BITS;

  logic signed [DW-1:0] diff_r, diff_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] coord_r, coord_nxt;
  logic [CW-1:0] lim;
  logic [HW-1:0] hi;

  always_comb begin
    diff_nxt = DW'(x) - DW'(dmin);
    prod_nxt = PW'(diff_r) * PW'($signed({1'b0, scale}));
    lim = {size - 6'd1, 16'd0} - CW'(1);
    hi = prod_r[PW-1:lutm_pkg::FRAC_BITS];
    if (prod_r <= 0) begin
      coord_nxt = '0;
    end else if (hi > HW'(lim)) begin
      coord_nxt = lim;
    end else begin
      coord_nxt = hi[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r  <= diff_nxt;
      prod_r  <= prod_nxt;
      coord_r <= coord_nxt;
    end
  end

  assign crd  = coord_r[CW-1:lutm_pkg::FRAC_BITS];
  assign frac = coord_r[lutm_pkg::FRAC_BITS-1:0];
endmodule
`default_nettype wire

>>> rtl/core/lutm_lerp.sv
// One registered linear blend a + round((b - a) * f / 2^16).
// Uses lutm_pkg for sample and fraction widths.
`default_nettype none
module lutm_lerp (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire lutm_pkg::sample_t              a,
  input  wire lutm_pkg::sample_t              b,
  input  wire logic [lutm_pkg::FRAC_BITS-1:0] f,
  output lutm_pkg::sample_t                   q
);
  localparam int DW = lutm_pkg::SAMPLE_BITS + 1;
  localparam int TW = DW + lutm_pkg::FRAC_BITS + 1;

  logic signed [DW-1:0] diff;
  logic signed [TW-1:0] t;
  logic [DW-1:0] sum;
  lutm_pkg::sample_t q_r;

  always_comb begin
    diff = DW'(b) - DW'(a);
    t = TW'(diff) * TW'($signed({1'b0, f})) + (TW'(1) <<< (lutm_pkg::FRAC_BITS - 1));
    sum = DW'(a) + t[TW-2:lutm_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= sum[lutm_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

>>> rtl/core/lut3d_trilinear_color_map.sv
// Top level of the trilinear 3D color cube mapper.
// Depends on lutm_pkg, lutm_remap, lutm_ram and lutm_lerp.
//
// Channel  Direction  Contents
// in_      slave      tdata: entry_index, entry_red/green/blue, pixel_red/green/blue;
//                     tuser: opcode; tlast: row_end
// out_     master     tdata: out_red/green/blue; tlast: out_row_end
// cfg_     write      register index and data, one write per cycle
//
// One item enters per cycle while the output does not stall; only pixel items give a result.
// The pipeline has eight stages: three remap, address, table read, three blends.
// Eight table copies give the eight neighbor reads in the same cycle.
// The whole pipeline holds while the output waits; reset is synchronous, active low.
`default_nettype none
module lut3d_trilinear_color_map (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,  // entry_index, entry r/g/b, pixel r/g/b
  input  wire logic         in_tuser,  // opcode
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [63:0]  out_tdata, // out_red, out_green, out_blue, zero pad
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [lutm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lutm_pkg::SCALE_W-1:0]   cfg_wdata
);
  localparam int SB = lutm_pkg::SAMPLE_BITS;
  localparam int FB = lutm_pkg::FRAC_BITS;
  localparam int AW = lutm_pkg::ADDR_W;

  logic [lutm_pkg::SIZE_W-1:0] cube_size_r;
  logic [lutm_pkg::SCALE_W-1:0] scale_r [3];
  lutm_pkg::sample_t dmin_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_size_r <= 6'd33;
      for (int c = 0; c < 3; c++) begin
        scale_r[c] <= 24'd2097152;
        dmin_r[c]  <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lutm_pkg::REG_CUBE_SIZE:   cube_size_r <= cfg_wdata[lutm_pkg::SIZE_W-1:0];
        lutm_pkg::REG_SCALE_RED:   scale_r[0] <= cfg_wdata;
        lutm_pkg::REG_SCALE_GREEN: scale_r[1] <= cfg_wdata;
        lutm_pkg::REG_SCALE_BLUE:  scale_r[2] <= cfg_wdata;
        lutm_pkg::REG_DMIN_RED:    dmin_r[0] <= cfg_wdata[SB-1:0];
        lutm_pkg::REG_DMIN_GREEN:  dmin_r[1] <= cfg_wdata[SB-1:0];
        lutm_pkg::REG_DMIN_BLUE:   dmin_r[2] <= cfg_wdata[SB-1:0];
        default: ;
      endcase
    end
  end

  logic [lutm_pkg::SIZE_W-1:0] size_use;
  logic [lutm_pkg::SQ_W-1:0] size_sq;
  always_comb begin
    if (cube_size_r < 6'd2) begin
      size_use = 6'd2;
    end else if (cube_size_r > 6'(lutm_pkg::MAX_CUBE_SIZE)) begin
      size_use = 6'(lutm_pkg::MAX_CUBE_SIZE);
    end else begin
      size_use = cube_size_r;
    end
    size_sq = lutm_pkg::SQ_W'(size_use) * lutm_pkg::SQ_W'(size_use);
  end

  logic en, out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  lutm_pkg::side_t side_r [1:4];
  lutm_pkg::side_t side_nxt;
  always_comb begin
    side_nxt.valid = in_tvalid;
    side_nxt.pixel = (in_tuser == lutm_pkg::OP_PIXEL);
    side_nxt.last  = in_tlast;
    side_nxt.idx   = in_tdata[15:0];
    side_nxt.entry = in_tdata[75:16];
  end

  logic [lutm_pkg::SIZE_W-1:0] crd [3];
  logic [FB-1:0] frac [3];
  for (genvar c = 0; c < 3; c++) begin : g_remap
    lutm_remap u_remap (
      .clk(clk), .en(en), .x(in_tdata[76+SB*c +: SB]), .dmin(dmin_r[c]),
      .scale(scale_r[c]), .size(size_use), .crd(crd[c]), .frac(frac[c])
    );
  end

  logic [AW-1:0] base_r;
  logic [FB-1:0] fr4_r [3];
  logic [FB-1:0] fr5_r [3];
  logic [FB-1:0] fr6_r [3];
  logic [FB-1:0] fr7_r [3];
  logic v5_r, v6_r, v7_r, l5_r, l6_r, l7_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= 4; s++) begin
        side_r[s].valid <= 1'b0;
      end
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      side_r[1] <= side_nxt;
      for (int s = 2; s <= 4; s++) begin
        side_r[s] <= side_r[s-1];
      end
      v5_r <= side_r[4].valid && side_r[4].pixel;
      v6_r <= v5_r;
      v7_r <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= AW'(crd[0]) + AW'(crd[1]) * AW'(size_use) + AW'(crd[2]) * AW'(size_sq);
      fr4_r <= frac;
      fr5_r <= fr4_r;
      fr6_r <= fr5_r;
      fr7_r <= fr6_r;
      l5_r <= side_r[4].last;
      l6_r <= l5_r;
      l7_r <= l6_r;
      last_r <= l7_r;
    end
  end

  logic ram_we, ram_re;
  assign ram_we = en && side_r[4].valid && !side_r[4].pixel &&
                  (side_r[4].idx < AW'(lutm_pkg::TABLE_DEPTH));
  assign ram_re = en && side_r[4].valid && side_r[4].pixel;

  logic [lutm_pkg::ENTRY_W-1:0] rd [8];
  for (genvar n = 0; n < 8; n++) begin : g_bank
    logic [AW-1:0] raddr;
    assign raddr = base_r + AW'(n % 2) + (((n / 2) % 2 == 1) ? AW'(size_use) : '0)
                 + ((n / 4 == 1) ? AW'(size_sq) : '0);
    lutm_ram #(.WIDTH(lutm_pkg::ENTRY_W), .DEPTH(lutm_pkg::TABLE_DEPTH)) u_ram (
      .clk(clk), .we(ram_we), .waddr(side_r[4].idx), .wdata(side_r[4].entry),
      .re(ram_re), .raddr(raddr), .rdata(rd[n])
    );
  end

  lutm_pkg::sample_t x_q [3][4];
  lutm_pkg::sample_t y_q [3][2];
  lutm_pkg::sample_t z_q [3];
  for (genvar k = 0; k < 3; k++) begin : g_chan
    for (genvar j = 0; j < 4; j++) begin : g_l1
      lutm_lerp u_l1 (
        .clk(clk), .en(en), .a(rd[2*j][SB*k +: SB]), .b(rd[2*j+1][SB*k +: SB]),
        .f(fr5_r[0]), .q(x_q[k][j])
      );
    end
    for (genvar j = 0; j < 2; j++) begin : g_l2
      lutm_lerp u_l2 (
        .clk(clk), .en(en), .a(x_q[k][2*j]), .b(x_q[k][2*j+1]),
        .f(fr6_r[1]), .q(y_q[k][j])
      );
    end
    lutm_lerp u_l3 (
      .clk(clk), .en(en), .a(y_q[k][0]), .b(y_q[k][1]), .f(fr7_r[2]), .q(z_q[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'd0, z_q[2], z_q[1], z_q[0]};
endmodule
`default_nettype wire

>>> rtl/core/lutm_checker.sv
// Port-level checker for the color cube mapper, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lutm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);
  `LUTM_ASSERT_ALWAYS(a_no_result_after_reset, clk, $past(!rst_n) |-> !out_tvalid, "result right after reset")
  `LUTM_ASSERT(a_ready_follows_output, clk, rst_n, in_tready == (out_tready || !out_tvalid), "input ready not tied to output")
  `LUTM_ASSERT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
endmodule

bind lut3d_trilinear_color_map lutm_checker u_lutm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
